// ===== hw/rtl/nlp_pkg.sv =====
// nlp_pkg: shared types and constants for the next lexicographic permutation block.
// No dependencies; used by nlp_cmp and next_lexicographic_permutation.
package nlp_pkg;

    localparam int MAX_ELEMENTS_DEF  = 16;
    localparam int ELEMENT_WIDTH_DEF = 16;

    localparam int COUNT_W = 5;   // element_count register
    localparam int POS_W   = 4;   // position fields
    localparam int VALUE_W = 16;  // value fields

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd8;
    localparam logic [COUNT_W-1:0] COUNT_MIN   = 5'd2;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIV_RD,
        ST_PIV_CMP,
        ST_SWP_RD,
        ST_SWP_CMP,
        ST_SWP_WR_A,
        ST_SWP_WR_B,
        ST_REV_RD,
        ST_REV_WR_LO,
        ST_REV_WR_HI,
        ST_EMIT_RD,
        ST_EMIT_WAIT
    } nlp_state_t;

    // Operand selection of the shared comparator
    typedef enum logic {
        CMP_PIVOT,  // store[p-1] >= store[p]
        CMP_SUCC    // pivot >= store[s]
    } nlp_cmp_mode_t;

endpackage

// ===== hw/rtl/nlp_ram.sv =====
// nlp_ram: generic RAM, one write port, two read ports, registered read data.
// No dependencies.
module nlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_reg[rd_addr_a];
        rd_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== hw/rtl/nlp_cmp.sv =====
// nlp_cmp: shared magnitude comparator with operand select for pivot and successor scans.
// Depends on nlp_pkg.
module nlp_cmp #(
    parameter int WIDTH = nlp_pkg::ELEMENT_WIDTH_DEF
) (
    input  nlp_pkg::nlp_cmp_mode_t mode,
    input  logic [WIDTH-1:0]       rd_a,
    input  logic [WIDTH-1:0]       rd_b,
    input  logic [WIDTH-1:0]       pivot,
    output logic                   ge
);

    logic [WIDTH-1:0] lhs;

    always_comb begin
        unique case (mode)
            nlp_pkg::CMP_PIVOT: lhs = rd_a;
            nlp_pkg::CMP_SUCC:  lhs = pivot;
            default:            lhs = rd_a;
        endcase
    end

    // Right operand is always port B of the store
    assign ge = (lhs >= rd_b);

endmodule

// ===== hw/rtl/next_lexicographic_permutation.sv =====
// Usage:
//   Input channel (s_valid/s_ready) takes one request per handshake. A load request
//   (s_cmd = 0) writes s_value into list position s_position and returns
//   nothing. An advance request (s_cmd = 1) rewrites the first n positions into their
//   lexicographic successor and then emits n results on the m_ channel, positions
//   0..n-1 in order, m_last on the final one. A list already in non-increasing order
//   is reversed to non-decreasing order and every result carries m_wrapped = 1.
//   n is the element_count register (cfg_wr_en/cfg_wr_data), clamped to 2..MAX_ELEMENTS;
//   write it only while the block is idle.
// Sequence (n positions): pivot scan over adjacent pairs, successor scan, swap, suffix
//   reversal one pair at a time, then emission of the results. A single comparator serves
//   both scans, and the element store has two read ports and one write port.
//   s_ready is low from acceptance of an advance until its last result is taken.
// Reset: synchronous active-low aresetn returns to idle and sets element_count to 8.
//   The element store is not cleared; advancing over unloaded positions is undefined.
// Stall: m_valid and the result hold until m_ready; the sequencer waits meanwhile.
// Depends on nlp_pkg, nlp_ram, nlp_cmp.
module next_lexicographic_permutation #(
    parameter int MAX_ELEMENTS  = nlp_pkg::MAX_ELEMENTS_DEF,
    parameter int ELEMENT_WIDTH = nlp_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [nlp_pkg::COUNT_W-1:0]       cfg_wr_data,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic [nlp_pkg::POS_W-1:0]         s_position,
    input  logic [nlp_pkg::VALUE_W-1:0]       s_value,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [nlp_pkg::POS_W-1:0]         m_out_position,
    output logic [nlp_pkg::VALUE_W-1:0]       m_out_value,
    output logic                              m_last,
    output logic                              m_wrapped
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam logic [AW-1:0] IDX_ZERO = AW'(0);
    localparam logic [AW-1:0] IDX_ONE  = AW'(1);
    localparam logic [AW-1:0] IDX_MAX  = AW'(MAX_ELEMENTS - 1);
    localparam logic [nlp_pkg::COUNT_W-1:0] MAX_CNT = nlp_pkg::COUNT_W'(MAX_ELEMENTS);

    nlp_pkg::nlp_state_t state_reg, state_next;

    logic [nlp_pkg::COUNT_W-1:0] count_reg;
    logic [AW-1:0] last_reg, last_next;     // n-1
    logic [AW-1:0] p_reg, p_next;           // right neighbor of pivot candidate
    logic [AW-1:0] s_reg, s_next;           // successor scan index
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [AW-1:0] k_reg, k_next;           // emit index
    logic [ELEMENT_WIDTH-1:0] pivot_reg, pivot_next;
    logic [ELEMENT_WIDTH-1:0] hold_reg, hold_next;
    logic wrap_reg, wrap_next;

    // store port signals
    logic                     ram_we;
    logic [AW-1:0]            ram_wr_addr;
    logic [ELEMENT_WIDTH-1:0] ram_wr_data;
    logic [AW-1:0]            ram_rd_addr_a;
    logic [AW-1:0]            ram_rd_addr_b;
    logic [ELEMENT_WIDTH-1:0] ram_rd_data_a;
    logic [ELEMENT_WIDTH-1:0] ram_rd_data_b;

    nlp_pkg::nlp_cmp_mode_t cmp_mode;
    logic                   cmp_ge;

    logic [AW-1:0]            clamp_last;
    logic                     pos_ok;
    logic [ELEMENT_WIDTH-1:0] load_val;
    logic                     emit_last;

    nlp_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (ram_we),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_addr_a (ram_rd_addr_a),
        .rd_addr_b (ram_rd_addr_b),
        .rd_data_a (ram_rd_data_a),
        .rd_data_b (ram_rd_data_b)
    );

    nlp_cmp #(
        .WIDTH (ELEMENT_WIDTH)
    ) u_cmp (
        .mode  (cmp_mode),
        .rd_a  (ram_rd_data_a),
        .rd_b  (ram_rd_data_b),
        .pivot (pivot_reg),
        .ge    (cmp_ge)
    );

    // n-1 with element_count clamped to 2..MAX_ELEMENTS
    always_comb begin
        if (count_reg < nlp_pkg::COUNT_MIN) begin
            clamp_last = IDX_ONE;
        end else if (count_reg > MAX_CNT) begin
            clamp_last = IDX_MAX;
        end else begin
            clamp_last = AW'(count_reg - nlp_pkg::COUNT_W'(1));
        end
    end

    assign pos_ok    = (nlp_pkg::COUNT_W'(s_position) < MAX_CNT);
    assign load_val  = ELEMENT_WIDTH'(s_value);
    assign emit_last = (k_reg == last_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            nlp_pkg::ST_IDLE: begin
                if (s_valid && (s_cmd == nlp_pkg::CMD_ADVANCE)) begin
                    state_next = nlp_pkg::ST_PIV_RD;
                end
            end
            nlp_pkg::ST_PIV_RD:  state_next = nlp_pkg::ST_PIV_CMP;
            nlp_pkg::ST_PIV_CMP: begin
                if (!cmp_ge) begin
                    state_next = nlp_pkg::ST_SWP_RD;
                end else if (p_reg == IDX_ONE) begin
                    state_next = nlp_pkg::ST_REV_RD;   // fully descending: wrap
                end
            end
            nlp_pkg::ST_SWP_RD:  state_next = nlp_pkg::ST_SWP_CMP;
            nlp_pkg::ST_SWP_CMP: begin
                if (!cmp_ge) begin
                    state_next = nlp_pkg::ST_SWP_WR_A;
                end
            end
            nlp_pkg::ST_SWP_WR_A:  state_next = nlp_pkg::ST_SWP_WR_B;
            nlp_pkg::ST_SWP_WR_B:  state_next = nlp_pkg::ST_REV_RD;
            nlp_pkg::ST_REV_RD: begin
                if (lo_reg < hi_reg) begin
                    state_next = nlp_pkg::ST_REV_WR_LO;
                end else begin
                    state_next = nlp_pkg::ST_EMIT_RD;
                end
            end
            nlp_pkg::ST_REV_WR_LO: state_next = nlp_pkg::ST_REV_WR_HI;
            nlp_pkg::ST_REV_WR_HI: state_next = nlp_pkg::ST_REV_RD;
            nlp_pkg::ST_EMIT_RD:   state_next = nlp_pkg::ST_EMIT_WAIT;
            nlp_pkg::ST_EMIT_WAIT: begin
                if (m_ready) begin
                    state_next = emit_last ? nlp_pkg::ST_IDLE : nlp_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = nlp_pkg::ST_IDLE;
        endcase
    end

    // Outputs: store ports, comparator select, datapath updates
    always_comb begin
        ram_we        = 1'b0;
        ram_wr_addr   = lo_reg;
        ram_wr_data   = hold_reg;
        ram_rd_addr_a = lo_reg;
        ram_rd_addr_b = hi_reg;
        cmp_mode      = nlp_pkg::CMP_PIVOT;
        last_next     = last_reg;
        p_next        = p_reg;
        s_next        = s_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        k_next        = k_reg;
        pivot_next    = pivot_reg;
        hold_next     = hold_reg;
        wrap_next     = wrap_reg;
        unique case (state_reg)
            nlp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == nlp_pkg::CMD_LOAD) begin
                        ram_we      = pos_ok;
                        ram_wr_addr = AW'(s_position);
                        ram_wr_data = load_val;
                    end else begin
                        last_next = clamp_last;
                        p_next    = clamp_last;
                    end
                end
            end
            nlp_pkg::ST_PIV_RD: begin
                ram_rd_addr_a = p_reg - IDX_ONE;
                ram_rd_addr_b = p_reg;
            end
            nlp_pkg::ST_PIV_CMP: begin
                // next pair fetched speculatively
                ram_rd_addr_a = p_reg - IDX_ONE - IDX_ONE;
                ram_rd_addr_b = p_reg - IDX_ONE;
                if (cmp_ge) begin
                    if (p_reg == IDX_ONE) begin
                        lo_next   = IDX_ZERO;
                        hi_next   = last_reg;
                        wrap_next = 1'b1;
                    end else begin
                        p_next = p_reg - IDX_ONE;
                    end
                end else begin
                    pivot_next = ram_rd_data_a;
                    s_next     = last_reg;
                    wrap_next  = 1'b0;
                end
            end
            nlp_pkg::ST_SWP_RD: begin
                ram_rd_addr_b = s_reg;
            end
            nlp_pkg::ST_SWP_CMP: begin
                cmp_mode      = nlp_pkg::CMP_SUCC;
                ram_rd_addr_b = s_reg - IDX_ONE;
                if (cmp_ge) begin
                    s_next = s_reg - IDX_ONE;
                end else begin
                    hold_next = ram_rd_data_b;
                end
            end
            nlp_pkg::ST_SWP_WR_A: begin
                ram_we      = 1'b1;
                ram_wr_addr = p_reg - IDX_ONE;
                ram_wr_data = hold_reg;
            end
            nlp_pkg::ST_SWP_WR_B: begin
                ram_we      = 1'b1;
                ram_wr_addr = s_reg;
                ram_wr_data = pivot_reg;
                lo_next     = p_reg;
                hi_next     = last_reg;
            end
            nlp_pkg::ST_REV_RD: begin
                ram_rd_addr_a = lo_reg;
                ram_rd_addr_b = hi_reg;
                if (!(lo_reg < hi_reg)) begin
                    k_next = IDX_ZERO;
                end
            end
            nlp_pkg::ST_REV_WR_LO: begin
                ram_we      = 1'b1;
                ram_wr_addr = lo_reg;
                ram_wr_data = ram_rd_data_b;
                hold_next   = ram_rd_data_a;
            end
            nlp_pkg::ST_REV_WR_HI: begin
                ram_we      = 1'b1;
                ram_wr_addr = hi_reg;
                ram_wr_data = hold_reg;
                lo_next     = lo_reg + IDX_ONE;
                hi_next     = hi_reg - IDX_ONE;
            end
            nlp_pkg::ST_EMIT_RD: begin
                ram_rd_addr_a = k_reg;
            end
            nlp_pkg::ST_EMIT_WAIT: begin
                // address held so the registered read data stays put while stalled
                ram_rd_addr_a = k_reg;
                if (m_ready && !emit_last) begin
                    k_next = k_reg + IDX_ONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nlp_pkg::ST_IDLE;
            count_reg <= nlp_pkg::COUNT_RESET;
            wrap_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            wrap_reg  <= wrap_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        last_reg  <= last_next;
        p_reg     <= p_next;
        s_reg     <= s_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        k_reg     <= k_next;
        pivot_reg <= pivot_next;
        hold_reg  <= hold_next;
    end

    assign s_ready        = (state_reg == nlp_pkg::ST_IDLE);
    assign m_valid        = (state_reg == nlp_pkg::ST_EMIT_WAIT);
    assign m_out_position = nlp_pkg::POS_W'(k_reg);
    assign m_out_value    = nlp_pkg::VALUE_W'(ram_rd_data_a);
    assign m_last         = emit_last;
    assign m_wrapped      = wrap_reg;

`ifndef SYNTH
    // Never accept a request while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request side ready while result pending");

    // An advance closes the request side until its results are out
    a_adv_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_cmd == nlp_pkg::CMD_ADVANCE)) |=> !s_ready)
        else $error("ready right after advance accepted");

    // A load returns the request side to ready in the next cycle
    a_load_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_cmd == nlp_pkg::CMD_LOAD)) |=> s_ready)
        else $error("load did not return to idle");

    // After the last result is taken the block is idle again
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (s_ready && !m_valid))
        else $error("not idle after last result");
`endif

endmodule

// ===== verif/tb_next_lexicographic_permutation.sv =====
`timescale 1ns / 100ps
// tb_next_lexicographic_permutation: self-checking testbench for the permutation engine.
// Predicts each emitted list in a local shadow store and checks every result.
// Depends on nlp_pkg and next_lexicographic_permutation.
module tb_next_lexicographic_permutation;

    localparam int LIST_DEPTH     = nlp_pkg::MAX_ELEMENTS_DEF;
    localparam int SETTLE_CYCLES  = 120;   // longer than one n = 16 advance, no stall
    localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before the run is abandoned
    localparam int NUM_PHASES     = 9;
    localparam int PHASE_ITEMS    = 37;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic                        cmd;
        logic [nlp_pkg::POS_W-1:0]   position;
        logic [nlp_pkg::VALUE_W-1:0] value;
    } perm_req_t;

    typedef struct packed {
        logic [nlp_pkg::POS_W-1:0]   position;
        logic [nlp_pkg::VALUE_W-1:0] value;
        logic                        last;
        logic                        wrapped;
    } perm_emit_t;

    // DUT connections; every input starts at a known value
    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [nlp_pkg::COUNT_W-1:0] cfg_wr_data = '0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    logic                        s_cmd       = nlp_pkg::CMD_LOAD;
    logic [nlp_pkg::POS_W-1:0]   s_position  = '0;
    logic [nlp_pkg::VALUE_W-1:0] s_value     = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    logic [nlp_pkg::POS_W-1:0]   m_out_position;
    logic [nlp_pkg::VALUE_W-1:0] m_out_value;
    logic                        m_last;
    logic                        m_wrapped;

    // Shadow of the block: element list and element_count register
    logic [nlp_pkg::VALUE_W-1:0] shadow_list [LIST_DEPTH];
    logic [nlp_pkg::COUNT_W-1:0] shadow_count = nlp_pkg::COUNT_RESET;

    perm_req_t  req_backlog[$];     // requests waiting for the driver
    perm_emit_t expected_emits[$];  // results predicted but not yet seen
    perm_req_t  held_req;           // request currently on the s_ channel

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    int unsigned mismatch_count = 0;
    int unsigned load_count     = 0;
    int unsigned advance_count  = 0;
    int unsigned wrap_count     = 0;
    int unsigned result_count   = 0;
    int unsigned quiet_cycles   = 0;

    next_lexicographic_permutation dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_position     (s_position),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_position (m_out_position),
        .m_out_value    (m_out_value),
        .m_last         (m_last),
        .m_wrapped      (m_wrapped)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // element_count is clamped into 2..MAX_ELEMENTS by the block
    function automatic int positions_in_use(logic [nlp_pkg::COUNT_W-1:0] cnt);
        if (cnt < nlp_pkg::COUNT_MIN) return int'(nlp_pkg::COUNT_MIN);
        if (cnt > LIST_DEPTH) return LIST_DEPTH;
        return int'(cnt);
    endfunction

    function automatic void reverse_span(int lo, int hi);
        logic [nlp_pkg::VALUE_W-1:0] tmp;
        while (lo < hi) begin
            tmp             = shadow_list[lo];
            shadow_list[lo] = shadow_list[hi];
            shadow_list[hi] = tmp;
            lo++;
            hi--;
        end
    endfunction

    // Rewrites the first n entries into their lexicographic successor and
    // queues the n results the block must emit.
    function automatic void predict_successor();
        int                          n;
        int                          piv;
        int                          succ;
        logic                        wrap;
        logic [nlp_pkg::VALUE_W-1:0] tmp;
        perm_emit_t                  emit;
        n    = positions_in_use(shadow_count);
        piv  = n - 1;
        wrap = 1'b0;
        // pivot search: non-strict, so runs of equal values are skipped
        while (piv > 0 && shadow_list[piv-1] >= shadow_list[piv]) piv--;
        if (piv == 0) begin
            // already in final (non-increasing) order: wrap to ascending
            reverse_span(0, n - 1);
            wrap = 1'b1;
            wrap_count++;
        end else begin
            succ = n - 1;
            while (shadow_list[succ] <= shadow_list[piv-1]) succ--;
            tmp                 = shadow_list[piv-1];
            shadow_list[piv-1]  = shadow_list[succ];
            shadow_list[succ]   = tmp;
            reverse_span(piv, n - 1);
        end
        for (int k = 0; k < n; k++) begin
            emit.position = nlp_pkg::POS_W'(k);
            emit.value    = shadow_list[k];
            emit.last     = (k == n - 1);
            emit.wrapped  = wrap;
            expected_emits.push_back(emit);
        end
    endfunction

    function automatic void apply_request(perm_req_t req);
        if (req.cmd == nlp_pkg::CMD_LOAD) begin
            shadow_list[req.position] = req.value;
            load_count++;
        end else begin
            advance_count++;
            predict_successor();
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: one request per handshake, random gaps between requests
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : request_driver
        perm_req_t nxt;
        logic      taken;
        taken = s_valid && s_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (taken) apply_request(held_req);
            // valid holds with the same payload until the request is taken
            if (!s_valid || taken) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt        = req_backlog.pop_front();
                    held_req   = nxt;
                    s_valid    <= 1'b1;
                    s_cmd      <= nxt.cmd;
                    s_position <= nxt.position;
                    s_value    <= nxt.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        perm_emit_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_emits.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("[%0t] unexpected result: pos %0d value %h last %b wrapped %b",
                                 $realtime, m_out_position, m_out_value, m_last, m_wrapped);
                end else begin
                    want = expected_emits.pop_front();
                    if (m_out_position !== want.position || m_out_value !== want.value ||
                        m_last !== want.last || m_wrapped !== want.wrapped) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"[%0t] result mismatch: expected pos %0d value %h ",
                                      "last %b wrapped %b, got pos %0d value %h last %b ",
                                      "wrapped %b"}, $realtime,
                                     want.position, want.value, want.last, want.wrapped,
                                     m_out_position, m_out_value, m_last, m_wrapped);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: any handshake on either channel counts as progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, expected_emits.size());
                $display("next_lexicographic_permutation regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void push_req(logic cmd, int pos, logic [nlp_pkg::VALUE_W-1:0] val);
        perm_req_t r;
        r.cmd      = cmd;
        r.position = nlp_pkg::POS_W'(pos);
        r.value    = val;
        req_backlog.push_back(r);
    endfunction

    // Fixed opening: value extremes, a descending list that must wrap, a plain
    // step, duplicates, and non-zero unused fields on advance requests.
    function automatic void queue_directed();
        logic [nlp_pkg::VALUE_W-1:0] seed_vals [LIST_DEPTH] = '{
            16'hFFFF, 16'hAAAA, 16'h8000, 16'h5555, 16'h0100, 16'h00FF, 16'h0001, 16'h0000,
            16'h1234, 16'h0F0F, 16'hF0F0, 16'h7FFF, 16'h0002, 16'h3333, 16'hCCCC, 16'h0004};
        // every position is loaded once so no advance ever reads an unwritten entry
        for (int k = 0; k < LIST_DEPTH; k++) push_req(nlp_pkg::CMD_LOAD, k, seed_vals[k]);
        push_req(nlp_pkg::CMD_ADVANCE, 15, 16'hFFFF);   // descending -> wraps to ascending
        push_req(nlp_pkg::CMD_ADVANCE, 0, 16'h0000);    // swaps the last pair
        push_req(nlp_pkg::CMD_LOAD, 5, 16'hFFFF);       // equal neighbors in the suffix
        push_req(nlp_pkg::CMD_ADVANCE, 10, 16'h5A5A);
        push_req(nlp_pkg::CMD_LOAD, 7, 16'h0000);
        push_req(nlp_pkg::CMD_ADVANCE, 3, 16'hA5A5);
    endfunction

    // Mostly complete list loads followed by a run of advances; the rest is
    // stray loads and lone advances.
    function automatic void queue_random_traffic(int n, int budget);
        logic [nlp_pkg::VALUE_W-1:0] vals [LIST_DEPTH];
        logic [nlp_pkg::VALUE_W-1:0] walk;
        int                          made;
        int                          kind;
        int                          style;
        int                          start;
        int                          step;
        int                          steps;
        made = 0;
        while (made < budget) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                style = $urandom_range(4);
                walk  = nlp_pkg::VALUE_W'($urandom_range(16'hFFFF));
                for (int k = 0; k < n; k++) begin
                    step = $urandom_range(0, 4000);
                    case (style)
                        0: vals[k] = nlp_pkg::VALUE_W'($urandom_range(16'hFFFF));
                        1: vals[k] = nlp_pkg::VALUE_W'($urandom_range(3));  // heavy duplicates
                        2: begin                                     // non-increasing
                            vals[k] = walk;
                            walk    = (walk >= step) ? walk - nlp_pkg::VALUE_W'(step) : '0;
                        end
                        3: begin                                     // non-decreasing
                            vals[k] = walk;
                            walk    = (int'(walk) + step > 16'hFFFF)
                                      ? 16'hFFFF : walk + nlp_pkg::VALUE_W'(step);
                        end
                        default: vals[k] = nlp_pkg::VALUE_W'($urandom_range(15));
                    endcase
                end
                start = $urandom_range(n - 1);
                for (int k = 0; k < n; k++)
                    push_req(nlp_pkg::CMD_LOAD, (start + k) % n, vals[(start + k) % n]);
                steps = (n <= 3) ? $urandom_range(1, 7) : $urandom_range(1, 4);
                for (int k = 0; k < steps; k++)
                    push_req(nlp_pkg::CMD_ADVANCE, $urandom_range(15),
                             nlp_pkg::VALUE_W'($urandom_range(16'hFFFF)));
                made += n + steps;
            end else if (kind < 85) begin
                push_req(nlp_pkg::CMD_LOAD, $urandom_range(15),
                         nlp_pkg::VALUE_W'($urandom_range(16'hFFFF)));
                made++;
            end else begin
                push_req(nlp_pkg::CMD_ADVANCE, $urandom_range(15),
                         nlp_pkg::VALUE_W'($urandom_range(16'hFFFF)));
                made++;
            end
        end
    endfunction

    // Waits until everything sent is answered, then lets the engine settle
    // (a trailing load produces no result).
    task automatic wait_quiescent();
        do @(negedge aclk);
        while (req_backlog.size() != 0 || s_valid || expected_emits.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_element_count(logic [nlp_pkg::COUNT_W-1:0] cnt);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cnt;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow_count = cnt;
    endtask

    initial begin : sequencer
        logic [nlp_pkg::COUNT_W-1:0] phase_count [NUM_PHASES];
        phase_count = '{5'd8, 5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd17, 5'd5, 5'd0};
        phase_count[NUM_PHASES-1] = nlp_pkg::COUNT_W'($urandom_range(3, 15));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // phase 0 runs at the reset count, the others reprogram it while idle
            if (ph != 0) write_element_count(phase_count[ph]);
            case (ph % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 55; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            if (ph == 0) queue_directed();
            queue_random_traffic(positions_in_use(shadow_count), PHASE_ITEMS);
            wait_quiescent();
        end

        if (expected_emits.size() != 0) mismatch_count += expected_emits.size();
        $display("covered %0d phases, element counts 0..31 incl. clamping; %0d loads, %0d advances",
                 NUM_PHASES, load_count, advance_count);
        $display("checked %0d results, %0d wrapped advances, %0d mismatches",
                 result_count, wrap_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("next_lexicographic_permutation regression: pass");
        end else begin
            $display("next_lexicographic_permutation regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/nlp_pkg.sv
hw/rtl/nlp_ram.sv
hw/rtl/nlp_cmp.sv
hw/rtl/next_lexicographic_permutation.sv
verif/tb_next_lexicographic_permutation.sv
